[sv/tekd_pkg.sv]
package tekd_pkg;

  localparam int MAX_SEQ_LEN = 16;
  localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);
  localparam int KEEP_BYTES = 4;

  localparam logic [7:0] CHR_ESC = 8'd27;
  localparam logic [7:0] CHR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHR_TILDE = 8'h7E;
  localparam logic [7:0] CHR_UP = 8'h41;
  localparam logic [7:0] CHR_DOWN = 8'h42;
  localparam logic [7:0] CHR_RIGHT = 8'h43;
  localparam logic [7:0] CHR_LEFT = 8'h44;
  localparam logic [7:0] CHR_FIVE = 8'h35;
  localparam logic [7:0] CHR_SIX = 8'h36;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd127;
  localparam logic [7:0] CTRL_LO = 8'd1;
  localparam logic [7:0] CTRL_HI = 8'd26;
  localparam logic [7:0] INTER_LO = 8'h20;
  localparam logic [7:0] INTER_HI = 8'h2F;
  localparam logic [7:0] PARAM_LO = 8'h30;
  localparam logic [7:0] PARAM_HI = 8'h3F;

  localparam logic [2:0] KC_NONE = 3'd0;
  localparam logic [2:0] KC_UP = 3'd1;
  localparam logic [2:0] KC_DOWN = 3'd2;
  localparam logic [2:0] KC_RIGHT = 3'd3;
  localparam logic [2:0] KC_LEFT = 3'd4;
  localparam logic [2:0] KC_PGUP = 3'd5;
  localparam logic [2:0] KC_PGDN = 3'd6;

  typedef enum logic [1:0] {
    ST_DEFAULT = 2'd0,
    ST_ESC = 2'd1,
    ST_PARAM = 2'd2,
    ST_INTER = 2'd3
  } parse_state_t;

  typedef logic [KEEP_BYTES-1:0][7:0] seq_bytes_t;

  typedef struct packed {
    logic [2:0] key_code;
    logic [6:0] char_code;
    logic       pressed;
  } keystroke_t;

endpackage

[sv/tekd_decode.sv]
module tekd_decode (
  input  tekd_pkg::seq_bytes_t seq_bytes,
  output tekd_pkg::keystroke_t keystroke
);
  import tekd_pkg::*;

  logic [7:0] b0, b1, b2, b3;

  assign b0 = seq_bytes[0];
  assign b1 = seq_bytes[1];
  assign b2 = seq_bytes[2];
  assign b3 = seq_bytes[3];

  always_comb begin
    keystroke = '0;
    if ((b0 >= PRINT_LO && b0 <= PRINT_HI) || (b0 >= CTRL_LO && b0 <= CTRL_HI)) begin
      keystroke.pressed = 1'b1;
      keystroke.char_code = b0[6:0];
    end else if (b0 == CHR_ESC && b1 == 8'd0) begin
      keystroke.pressed = 1'b1;
      keystroke.char_code = CHR_ESC[6:0];
    end else if (b0 == CHR_ESC && b1 == CHR_LBRACKET) begin
      keystroke.pressed = 1'b1;
      if (b2 == CHR_UP) begin
        keystroke.key_code = KC_UP;
      end else if (b2 == CHR_DOWN) begin
        keystroke.key_code = KC_DOWN;
      end else if (b2 == CHR_RIGHT) begin
        keystroke.key_code = KC_RIGHT;
      end else if (b2 == CHR_LEFT) begin
        keystroke.key_code = KC_LEFT;
      end else if (b2 == CHR_FIVE && b3 == CHR_TILDE) begin
        keystroke.key_code = KC_PGUP;
      end else if (b2 == CHR_SIX && b3 == CHR_TILDE) begin
        keystroke.key_code = KC_PGDN;
      end else begin
        keystroke.key_code = KC_NONE;
      end
    end
  end

endmodule

[sv/terminal_escape_key_decoder_unit.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: data_byte; tuser: action (1 = end of input or timeout)
// m_axis    out        tdata: pressed, char_code, key_code (from bit 0 up)
//
// One item per cycle unless the result stalls: an item enters the input register; from there
// its sequence state is updated and, if it ends a sequence, its key decode lands in the result register.
// The result is valid once its item has passed the input register and then the result register.
// Reset clears the parse state, the held bytes and both valid flags.
// A stalled result holds the stage; one more item then waits in the input register.
module terminal_escape_key_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] pressed, [7:1] char_code, [10:8] key_code
);
  import tekd_pkg::*;

  logic             in_valid;
  logic             in_action;
  logic [7:0]       in_byte;
  logic             out_valid;
  keystroke_t       out_event;

  parse_state_t     parse_state, parse_state_next;
  logic [LEN_W-1:0] seq_length, seq_length_next;
  seq_bytes_t       seq_bytes, seq_bytes_next;
  seq_bytes_t       dec_bytes;
  keystroke_t       dec_event;

  logic             advance;
  logic             emit;
  logic             seq_done;
  logic             in_inter;
  logic [LEN_W-1:0] length_inc;

  assign advance = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign length_inc = seq_length + LEN_W'(1);
  assign in_inter = (in_byte >= INTER_LO) && (in_byte <= INTER_HI);

  always_comb begin
    parse_state_next = parse_state;
    seq_done = 1'b0;
    unique case (parse_state)
      ST_DEFAULT: begin
        if (in_byte == CHR_ESC) parse_state_next = ST_ESC;
        else seq_done = 1'b1;
      end
      ST_ESC: begin
        if (in_byte == CHR_LBRACKET) parse_state_next = ST_PARAM;
        else seq_done = 1'b1;
      end
      ST_PARAM: begin
        if (!(in_byte >= PARAM_LO && in_byte <= PARAM_HI)) begin
          parse_state_next = ST_INTER;
          seq_done = !in_inter;
        end
      end
      ST_INTER: begin
        seq_done = !in_inter;
      end
      default: begin
        seq_done = 1'b1;
      end
    endcase
    if (length_inc >= LEN_W'(MAX_SEQ_LEN)) seq_done = 1'b1;
  end

  always_comb begin
    dec_bytes = seq_bytes;
    emit = 1'b0;
    if (in_action) begin
      emit = (seq_length != '0);
    end else begin
      if (seq_length < LEN_W'(KEEP_BYTES)) dec_bytes[seq_length[1:0]] = in_byte;
      emit = seq_done;
    end
    if (emit) begin
      seq_bytes_next = '0;
      seq_length_next = '0;
    end else if (in_action) begin
      seq_bytes_next = seq_bytes;
      seq_length_next = seq_length;
    end else begin
      seq_bytes_next = dec_bytes;
      seq_length_next = length_inc;
    end
  end

  tekd_decode u_decode (
    .seq_bytes (dec_bytes),
    .keystroke (dec_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
      parse_state <= ST_DEFAULT;
      seq_length <= '0;
      seq_bytes <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        out_valid <= emit;
        seq_length <= seq_length_next;
        seq_bytes <= seq_bytes_next;
        if (emit) parse_state <= ST_DEFAULT;
        else if (!in_action) parse_state <= parse_state_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
    if (advance && emit) out_event <= dec_event;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, out_event};

`ifndef SYNTHESIS
  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    (seq_length == '0) |-> (parse_state == ST_DEFAULT))
    else $error("parse state left default with no bytes held");

  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    seq_length < LEN_W'(MAX_SEQ_LEN))
    else $error("sequence length reached the limit without ending");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (seq_length == '0 && parse_state == ST_DEFAULT))
    else $error("sequence not cleared after a result");

  a_arrow_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[10:8] != KC_NONE) |->
      (m_axis_tdata[0] && m_axis_tdata[7:1] == 7'd0))
    else $error("key code with inconsistent result fields");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tekd_pkg::*;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END = 1'b1;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic       act;
    logic [7:0] c;
    logic       typed;
    logic       pr;
    logic [6:0] pc;
    logic [2:0] kc;
  } dir_row_t;

  localparam int N_DIR = 22;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    '{ACT_END,  8'h00,        1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, 8'h00,        1'b1, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, 8'd26,        1'b1, 1'b1, 7'd26,  KC_NONE},
    '{ACT_BYTE, 8'd32,        1'b1, 1'b1, 7'd32,  KC_NONE},
    '{ACT_BYTE, 8'd127,       1'b1, 1'b1, 7'd127, KC_NONE},
    '{ACT_BYTE, 8'd128,       1'b1, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, 8'd255,       1'b1, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_ESC,      1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_END,  8'h00,        1'b1, 1'b1, 7'd27,  KC_NONE},
    '{ACT_BYTE, CHR_ESC,      1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, 8'h78,        1'b1, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_ESC,      1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_LBRACKET, 1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_UP,       1'b1, 1'b1, 7'd0,   KC_UP},
    '{ACT_BYTE, CHR_ESC,      1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_LBRACKET, 1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_SIX,      1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_TILDE,    1'b1, 1'b1, 7'd0,   KC_PGDN},
    '{ACT_BYTE, CHR_ESC,      1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, CHR_LBRACKET, 1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_BYTE, 8'h21,        1'b0, 1'b0, 7'd0,   KC_NONE},
    '{ACT_END,  8'h00,        1'b0, 1'b0, 7'd0,   KC_NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = ACT_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  parse_state_t   parse_st = ST_DEFAULT;
  logic [LEN_W-1:0] held_len = '0;
  seq_bytes_t     held_bytes = '0;

  keystroke_t strokes_due [$];
  int err_count = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  terminal_escape_key_decoder_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit predict_key(input logic act, input logic [7:0] c,
                                     output keystroke_t ev);
    bit done;
    logic [7:0] b0, b1, b2, b3;
    done = 1'b0;
    ev = '0;
    if (act == ACT_END) begin
      if (held_len == 0) return 1'b0;
      done = 1'b1;
    end else begin
      if (held_len < KEEP_BYTES) held_bytes[held_len[1:0]] = c;
      held_len++;
      case (parse_st)
        ST_DEFAULT: begin
          if (c == CHR_ESC) parse_st = ST_ESC;
          else done = 1'b1;
        end
        ST_ESC: begin
          if (c == CHR_LBRACKET) parse_st = ST_PARAM;
          else done = 1'b1;
        end
        ST_PARAM: begin
          if (!(c >= PARAM_LO && c <= PARAM_HI)) begin
            parse_st = ST_INTER;
            done = !(c >= INTER_LO && c <= INTER_HI);
          end
        end
        default: begin
          done = !(c >= INTER_LO && c <= INTER_HI);
        end
      endcase
      if (held_len >= MAX_SEQ_LEN) done = 1'b1;
    end
    if (!done) return 1'b0;
    b0 = held_bytes[0];
    b1 = held_bytes[1];
    b2 = held_bytes[2];
    b3 = held_bytes[3];
    if ((b0 >= PRINT_LO && b0 <= PRINT_HI) || (b0 >= CTRL_LO && b0 <= CTRL_HI)) begin
      ev.pressed = 1'b1;
      ev.char_code = b0[6:0];
    end else if (b0 == CHR_ESC && b1 == 8'h00) begin
      ev.pressed = 1'b1;
      ev.char_code = CHR_ESC[6:0];
    end else if (b0 == CHR_ESC && b1 == CHR_LBRACKET) begin
      ev.pressed = 1'b1;
      if (b2 == CHR_UP) ev.key_code = KC_UP;
      else if (b2 == CHR_DOWN) ev.key_code = KC_DOWN;
      else if (b2 == CHR_RIGHT) ev.key_code = KC_RIGHT;
      else if (b2 == CHR_LEFT) ev.key_code = KC_LEFT;
      else if (b2 == CHR_FIVE && b3 == CHR_TILDE) ev.key_code = KC_PGUP;
      else if (b2 == CHR_SIX && b3 == CHR_TILDE) ev.key_code = KC_PGDN;
    end
    parse_st = ST_DEFAULT;
    held_len = '0;
    held_bytes = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_item(input logic act, input logic [7:0] c,
                           input bit typed, input keystroke_t want);
    keystroke_t ev;
    bit got;
    bit rdy;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= c;
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    got = predict_key(act, c, ev);
    if (typed) strokes_due.push_back(want);
    else if (got) strokes_due.push_back(ev);
    if (act == ACT_BYTE || got) items_sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(ACT_BYTE, c, 1'b0, '0);
  endtask

  task automatic send_end();
    send_item(ACT_END, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (strokes_due.size() != 0 && n < DRAIN_LIMIT);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(negedge clk) begin : result_check
    keystroke_t seen;
    keystroke_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[10:0];
      if (strokes_due.size() == 0) begin
        report_mismatch("result with none expected", int'(seen), 0);
      end else begin
        want = strokes_due.pop_front();
        if (seen.pressed !== want.pressed)
          report_mismatch("pressed", int'(seen.pressed), int'(want.pressed));
        if (seen.char_code !== want.char_code)
          report_mismatch("char_code", int'(seen.char_code), int'(want.char_code));
        if (seen.key_code !== want.key_code)
          report_mismatch("key_code", int'(seen.key_code), int'(want.key_code));
      end
    end
  end

  initial begin
    keystroke_t row_ev;
    int phase_end;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row_ev.pressed = DIR_ROWS[i].pr;
      row_ev.char_code = DIR_ROWS[i].pc;
      row_ev.key_code = DIR_ROWS[i].kc;
      send_item(DIR_ROWS[i].act, DIR_ROWS[i].c, DIR_ROWS[i].typed, row_ev);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      wait_drained();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(9))
          0: send_byte(8'($urandom_range(255)));
          1: send_byte(8'($urandom_range(1, 127)));
          2: begin
            send_byte(CHR_ESC);
            send_byte(CHR_LBRACKET);
            send_byte(8'(CHR_UP + $urandom_range(3)));
          end
          3: begin
            send_byte(CHR_ESC);
            send_byte(CHR_LBRACKET);
            send_byte($urandom_range(1) ? CHR_FIVE : CHR_SIX);
            send_byte(CHR_TILDE);
          end
          4: begin
            send_byte(CHR_ESC);
            send_byte(CHR_LBRACKET);
            n = ($urandom_range(7) == 0) ? $urandom_range(10, 16) : $urandom_range(3);
            repeat (n) send_byte(8'($urandom_range(PARAM_LO, PARAM_HI)));
            repeat ($urandom_range(2)) send_byte(8'($urandom_range(INTER_LO, INTER_HI)));
            if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
            else send_byte(8'($urandom_range(8'h40, 8'h7E)));
          end
          5: begin
            send_byte(CHR_ESC);
            send_end();
          end
          6: begin
            send_byte(CHR_ESC);
            if ($urandom_range(1)) send_byte(CHR_LBRACKET);
            send_byte(8'($urandom_range(255)));
          end
          7: begin
            send_byte(CHR_ESC);
            n = $urandom_range(3);
            if (n > 0) send_byte(CHR_LBRACKET);
            if (n > 1) send_byte($urandom_range(1) ? CHR_FIVE : CHR_SIX);
            if (n > 2) send_byte(8'($urandom_range(INTER_LO, INTER_HI)));
            send_end();
          end
          8: send_end();
          default: begin
            send_byte(CHR_ESC);
            send_byte(CHR_LBRACKET);
            if ($urandom_range(1)) repeat ($urandom_range(14, 20))
              send_byte(8'($urandom_range(PARAM_LO, PARAM_HI)));
            else repeat ($urandom_range(14, 20))
              send_byte(8'($urandom_range(INTER_LO, INTER_HI)));
          end
        endcase
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (strokes_due.size() != 0)
      report_mismatch("results never arrived", 0, strokes_due.size());
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
